// ===== rtl/pbba_pkg.sv =====
// Package for the parallel biquad bank average unit.
// Holds sizes, operation codes, the sequencer state type and saturation helpers.
// No dependencies.
`default_nettype none

package pbba_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int COEFS        = 5;
  localparam int STATES       = 2;
  localparam int COEF_DEPTH   = MAX_SECTIONS * COEFS;
  localparam int STATE_DEPTH  = MAX_SECTIONS * STATES;
  localparam int COEF_AW      = $clog2(COEF_DEPTH);
  localparam int STATE_AW     = $clog2(STATE_DEPTH);
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

  localparam int COEF_W  = 32;
  localparam int DATA_W  = 48;
  localparam int ACC_W   = 52;
  localparam int PROD_W  = 57;
  localparam int FULL_W  = 82;
  localparam int P_W     = 50;
  localparam int SUM_W   = DATA_W + $clog2(MAX_SECTIONS) + 2;
  localparam int N_W     = SUM_W - 16;
  localparam int Q_W     = N_W + 1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_COEF   = 2'd1,
    OP_STATE  = 2'd2,
    OP_NONE   = 2'd3
  } pbba_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_Y,
    ST_WB0,
    ST_WB1,
    ST_DIV,
    ST_OUT
  } pbba_state_t;

  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) return v[DATA_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(DATA_W-1){1'b0}}};
    else return {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-COEF_W:0] top;
    top = v[DATA_W-1:COEF_W-1];
    if ((&top) || !(|top)) return v[COEF_W-1:0];
    else if (v[DATA_W-1]) return {1'b1, {(COEF_W-1){1'b0}}};
    else return {1'b0, {(COEF_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pbba_ram.sv =====
// Generic synchronous RAM with one write and one registered read port.
// Entries never written since reset read as zero through per-entry valid bits.
`default_nettype none

module pbba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd;
  logic             rv;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rv  <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rv <= vld[raddr];
    end
  end

  assign rdata = rv ? rd : '0;

endmodule

`default_nettype wire

// ===== rtl/pbba_div.sv =====
// Serial floor divider of a signed value by a small positive count.
// One quotient bit per cycle; uses pbba_pkg for widths.
`default_nettype none

module pbba_div
  import pbba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic signed [N_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]      divisor,
  output logic                       busy,
  output logic signed [Q_W-1:0]      quotient
);

  localparam int IT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   m;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dv;
  logic             neg;
  logic [IT_W-1:0]  it;
  logic [CNT_W:0]   trial;
  logic             ge;
  logic signed [N_W:0] mag;

  // Floor of a negative value: negate, add divisor minus one, divide, negate.
  always_comb begin
    mag   = dividend[N_W-1] ? (-(N_W+1)'(dividend) + (N_W+1)'(divisor) - (N_W+1)'(1))
                            : (N_W+1)'(dividend);
    trial = {rem, m[N_W-1]};
    ge    = trial >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && it == IT_W'(N_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m   <= mag[N_W-1:0];
      rem <= '0;
      dv  <= divisor;
      neg <= dividend[N_W-1];
      it  <= '0;
    end else if (busy) begin
      m   <= {m[N_W-2:0], ge};
      rem <= ge ? CNT_W'(trial - {1'b0, dv}) : trial[CNT_W-1:0];
      it  <= it + IT_W'(1);
    end
  end

  assign quotient = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});

endmodule

`default_nettype wire

// ===== rtl/parallel_biquad_bank_average_unit.sv =====
// Top level of the parallel biquad bank average unit.
// Uses pbba_pkg, pbba_ram (coefficient and delay stores) and pbba_div.
//
// Usage. Transactions enter on in_valid/in_ready with fields op, sample, section,
// slot and value. A coefficient write (op 1) or delay-state write (op 2) is stored
// on acceptance and gives no result; op 3 is dropped. A sample (op 0) runs every
// active section through a transposed direct form II biquad and yields one result
// transaction on out_valid/out_ready carrying filtered and clipped.
// Per active section a sample makes the store reads, 5 products on one shared
// 32x25 multiplier that forms each product in two halves, then the output and the
// write-back; after the last section follow the serial divide by the section count
// and the load of the output register.
// One transaction is processed at a time; in_ready is high only when the
// sequencer is idle. The result sits in an output register, so a new
// transaction is accepted while an earlier result still waits for out_ready;
// a receiver that stalls holds the next finished result in the sequencer.
// The active_sections register is written by cfg_write/cfg_data at any edge.
// Synchronous reset returns the sequencer to idle, drops any pending result,
// sets active_sections to 1 and marks both stores as all zero at once.
`default_nettype none

module parallel_biquad_bank_average_unit
  import pbba_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [3:0]               cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               op,
  input  wire logic signed [23:0]       sample,
  input  wire logic [2:0]               section,
  input  wire logic [2:0]               slot,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [23:0]            filtered,
  output logic                          clipped
);

  pbba_state_t state, state_next;

  logic [3:0]       active_sections;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] sec;
  logic [2:0]       k;
  logic [2:0]       j;
  logic [1:0]       ph;

  logic signed [DATA_W-1:0] xs;
  logic signed [COEF_W-1:0] cf [COEFS];
  logic signed [DATA_W-1:0] z0, z1, y;
  logic signed [P_W-1:0]    p  [COEFS];
  logic signed [PROD_W-1:0] prod, prod_r, a_r;
  logic signed [FULL_W-1:0] full;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_rnd;

  logic signed [COEF_W-1:0] mul_c;
  logic signed [DATA_W-1:0] mul_v;
  logic signed [24:0]       mul_b;

  logic                     coef_we, st_we;
  logic [COEF_AW-1:0]       coef_waddr, coef_raddr;
  logic [STATE_AW-1:0]      st_waddr, st_raddr;
  logic [COEF_W-1:0]        coef_rdata;
  logic [DATA_W-1:0]        st_wdata, st_rdata;
  logic signed [DATA_W-1:0] z0_new, z1_new;

  logic                     accept, in_range_sec;
  logic                     div_start, div_busy, out_load;
  logic signed [Q_W-1:0]    quo;
  logic signed [23:0]       res;
  logic                     res_clip;

  logic [SEC_W-1:0] sec_idx;

  assign accept       = in_valid && in_ready;
  assign in_range_sec = int'(section) < MAX_SECTIONS;
  assign sec_idx      = sec[SEC_W-1:0];

  // Effective section count: zero acts as one, large values clamp.
  always_comb begin
    if (active_sections == 4'd0) cnt_eff = CNT_W'(1);
    else if (int'(active_sections) > MAX_SECTIONS) cnt_eff = CNT_W'(MAX_SECTIONS);
    else cnt_eff = CNT_W'(active_sections);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sections <= 4'd1;
    end else if (cfg_write) begin
      active_sections <= cfg_data;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && op == OP_SAMPLE) state_next = ST_LOAD;
      ST_LOAD: if (k == 3'd5) state_next = ST_MUL;
      ST_MUL: begin
        if (ph == 2'd2) begin
          if (j == 3'd0) state_next = ST_Y;
          else if (j == 3'(COEFS - 1)) state_next = ST_WB0;
        end
      end
      ST_Y:   state_next = ST_MUL;
      ST_WB0: state_next = ST_WB1;
      ST_WB1: state_next = (sec + CNT_W'(1) == cnt) ? ST_DIV : ST_LOAD;
      ST_DIV: if (!div_start && !div_busy) state_next = ST_OUT;
      ST_OUT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Arithmetic for the per-section update and the rounded sum for the divider.
  always_comb begin
    mul_c   = cf[j];
    mul_v   = (j < 3'd3) ? xs : y;
    mul_b   = (ph == 2'd0) ? {mul_v[DATA_W-1], mul_v[DATA_W-1:24]} : {1'b0, mul_v[23:0]};
    prod    = PROD_W'(mul_c) * PROD_W'(mul_b);
    // High half weighs 2^24; add half an LSB of Q9.39 before dropping 30 bits.
    full    = (FULL_W'(a_r) <<< 24) + FULL_W'(prod_r) + FULL_W'(64'sd536870912);
    z0_new  = sat48(ACC_W'(p[1]) - ACC_W'(p[3]) + ACC_W'(z1));
    z1_new  = sat48(ACC_W'(p[2]) - ACC_W'(p[4]));
    // The divider starts in the last write-back cycle, so the last output is added here.
    sum_rnd = sum + SUM_W'(y) + (SUM_W'(cnt) <<< 15);
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready   = (state == ST_IDLE);
    coef_we    = accept && op == OP_COEF && in_range_sec && int'(slot) < COEFS;
    coef_waddr = COEF_AW'(section) * COEF_AW'(COEFS) + COEF_AW'(slot);
    coef_raddr = COEF_AW'(sec_idx) * COEF_AW'(COEFS) + COEF_AW'(k);
    st_raddr   = STATE_AW'(sec_idx) * STATE_AW'(STATES) + STATE_AW'(k);
    st_we      = 1'b0;
    st_waddr   = STATE_AW'(section) * STATE_AW'(STATES) + STATE_AW'(slot);
    st_wdata   = value;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: st_we = accept && op == OP_STATE && in_range_sec && int'(slot) < STATES;
      ST_WB0: begin
        st_we    = 1'b1;
        st_waddr = STATE_AW'(sec_idx) * STATE_AW'(STATES);
        st_wdata = z0_new;
      end
      ST_WB1: begin
        st_we     = 1'b1;
        st_waddr  = STATE_AW'(sec_idx) * STATE_AW'(STATES) + STATE_AW'(1);
        st_wdata  = z1_new;
        div_start = (sec + CNT_W'(1) == cnt);
      end
      ST_OUT: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && op == OP_SAMPLE) begin
          xs  <= {{(DATA_W-40){sample[23]}}, sample, 16'd0};
          cnt <= cnt_eff;
          sec <= '0;
          k   <= '0;
          sum <= '0;
        end
      end
      ST_LOAD: begin
        if (k != 3'd0) cf[k - 3'd1] <= coef_rdata;
        if (k == 3'd1) z0 <= st_rdata;
        if (k == 3'd2) z1 <= st_rdata;
        k  <= k + 3'd1;
        j  <= '0;
        ph <= '0;
      end
      ST_MUL: begin
        if (ph == 2'd1) a_r <= prod_r;
        prod_r <= prod;
        if (ph == 2'd2) begin
          p[j] <= full[79:30];
          j    <= j + 3'd1;
          ph   <= '0;
        end else begin
          ph <= ph + 2'd1;
        end
      end
      ST_Y: y <= sat48(ACC_W'(p[0]) + ACC_W'(z0));
      ST_WB1: begin
        sum <= sum + SUM_W'(y);
        sec <= sec + CNT_W'(1);
        k   <= '0;
      end
      default: ;
    endcase
  end

  // Saturate the mean to Q1.23.
  always_comb begin
    if (quo > Q_W'(24'sh7FFFFF)) begin
      res = 24'sh7FFFFF; res_clip = 1'b1;
    end else if (quo < -Q_W'(25'sh800000)) begin
      res = -24'sh800000; res_clip = 1'b1;
    end else begin
      res = quo[23:0]; res_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered <= res;
      clipped  <= res_clip;
    end
  end

  pbba_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef (
    .clk   (clk),
    .rst   (rst),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (sat32(value)),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  pbba_ram #(.WIDTH(DATA_W), .DEPTH(STATE_DEPTH)) u_state (
    .clk   (clk),
    .rst   (rst),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  pbba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_rnd[SUM_W-1:16]),
    .divisor  (cnt),
    .busy     (div_busy),
    .quotient (quo)
  );

endmodule

`default_nettype wire

// ===== tb/parallel_biquad_bank_average_unit_tb.sv =====
// Self-checking testbench for the parallel biquad bank average unit.
// Depends on pbba_pkg and the unit's RTL; predicts results with its own biquad model.
`timescale 1ns / 100ps

module parallel_biquad_bank_average_unit_tb;
  import pbba_pkg::*;

  typedef struct {
    logic signed [23:0] filtered;
    logic               clipped;
  } bank_result_t;

  // Scoreboard: keeps its own copy of the coefficient and delay stores and
  // queues the expected mean for every sample transaction.
  class bank_scoreboard;
    longint coef_mem[MAX_SECTIONS*COEFS];
    longint delay_mem[MAX_SECTIONS*STATES];
    logic [3:0] active_reg;
    bank_result_t pending[$];
    int errors;

    function void clear();
      foreach (coef_mem[i]) coef_mem[i] = 0;
      foreach (delay_mem[i]) delay_mem[i] = 0;
      active_reg = 4'd1;
      pending.delete();
      errors = 0;
    endfunction

    function longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Coefficient product rounded half up back to Q9.39, done at 128 bits.
    function longint coef_product(longint c, longint v);
      logic signed [127:0] p;
      p = (128'(signed'(c)) * 128'(signed'(v))) + (128'sd1 <<< 29);
      p = p >>> 30;
      return longint'(p);
    endfunction

    function void note_input(logic [1:0] op, logic signed [23:0] smp, logic [2:0] sec,
                             logic [2:0] slt, logic signed [47:0] val);
      longint xs, sum, yn, d, num, q, c0, c1, c2, c3, c4;
      int n, b;
      bank_result_t r;
      case (op)
        OP_COEF: if (slt < COEFS) coef_mem[sec*COEFS + slt] = clamp(longint'(val), 32);
        OP_STATE: if (slt < STATES) delay_mem[sec*STATES + slt] = longint'(val);
        OP_SAMPLE: begin
          xs = longint'(smp) * 65536;
          n = (active_reg < 1) ? 1 : ((active_reg > MAX_SECTIONS) ? MAX_SECTIONS : active_reg);
          sum = 0;
          for (int s = 0; s < n; s++) begin
            b = s * COEFS;
            c0 = coef_mem[b]; c1 = coef_mem[b+1]; c2 = coef_mem[b+2];
            c3 = coef_mem[b+3]; c4 = coef_mem[b+4];
            yn = clamp(coef_product(c0, xs) + delay_mem[s*2], 48);
            delay_mem[s*2] = clamp(coef_product(c1, xs) - coef_product(c3, yn)
                                   + delay_mem[s*2+1], 48);
            delay_mem[s*2+1] = clamp(coef_product(c2, xs) - coef_product(c4, yn), 48);
            sum += yn;
          end
          d = longint'(n) * 65536;
          num = sum + d / 2;
          q = num / d;
          if (num % d != 0 && num < 0) q -= 1;
          r.clipped = (q > 8388607 || q < -8388608);
          r.filtered = 24'(clamp(q, 24));
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [23:0] f, logic c);
      bank_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result filtered=%0d clipped=%0b", f, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (f !== e.filtered) begin
        $error("filtered: expected %0d actual %0d", e.filtered, f);
        errors++;
      end
      if (c !== e.clipped) begin
        $error("clipped: expected %0b actual %0b", e.clipped, c);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [3:0] cfg_data = 4'd1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = OP_SAMPLE;
  logic signed [23:0] sample = '0;
  logic [2:0] section = '0;
  logic [2:0] slot = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] filtered;
  logic clipped;

  bank_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  parallel_biquad_bank_average_unit i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .sample(sample),
    .section(section), .slot(slot), .value(value), .out_valid(out_valid),
    .out_ready(out_ready), .filtered(filtered), .clipped(clipped)
  );

  // Receiver: random stalls, plus a long hold-off while hold_off is raised.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(filtered, clipped);
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted transaction or taken result. The limit
  // lies above the longest sample and the long receiver hold-off, so reaching it
  // means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 10000) begin
      $display("parallel_biquad_bank_average_unit_tb failed");
      $finish;
    end
  end

  // Offers one transaction and waits for its handshake. Random idle cycles
  // are inserted in front of it according to the current sender phase; valid
  // stays high after the handshake so that the next transaction can follow.
  task automatic send(logic [1:0] o, logic signed [23:0] smp, logic [2:0] sec,
                      logic [2:0] slt, logic signed [47:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o; sample <= smp; section <= sec; slot <= slt; value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_input(o, smp, sec, slt, val);
  endtask

  // Withdraws the sender, waits for all expected results, then lets the
  // sequencer settle so that a trailing write is certainly finished.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_sections(logic [3:0] n);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.active_reg = n;
  endtask

  function automatic logic signed [47:0] rand_coef();
    case ($urandom_range(3))
      0: return 48'(signed'($urandom_range(32'h7FFF, 0)) - 32'sh4000) <<< 14;
      1: return {{16{1'b0}}, 32'($urandom)} - 48'sh80000000;
      2: return 48'({$urandom, $urandom});
      default: return 48'($signed($urandom_range(1 << 28, 0)) - (1 << 27));
    endcase
  endfunction

  function automatic logic signed [23:0] rand_sample();
    if ($urandom_range(9) == 0) return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
    return 24'($urandom);
  endfunction

  // One random transaction: mostly samples and in-range writes, some noise.
  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 65) send(OP_SAMPLE, rand_sample(), 3'($urandom), 3'($urandom),
                     48'({$urandom, $urandom}));
    else if (k < 85) send(OP_COEF, 24'($urandom), 3'($urandom), 3'($urandom_range(4)),
                          rand_coef());
    else if (k < 93) send(OP_STATE, 24'($urandom), 3'($urandom), 3'($urandom_range(1)),
                          48'({$urandom, $urandom}) >>> $urandom_range(20));
    else if (k < 97) send(OP_COEF, 24'($urandom), 3'($urandom), 3'($urandom_range(7, 5)),
                          48'({$urandom, $urandom}));
    else send(($urandom_range(1)) ? OP_NONE : OP_STATE, 24'($urandom), 3'($urandom),
              3'($urandom_range(7, 2)), 48'({$urandom, $urandom}));
  endtask

  logic [3:0] settings[8] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2};

  initial begin
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset stores give zero, then identity and extreme coefficients and states, dropped writes.
    send(OP_SAMPLE, 24'sh7FFFFF, 0, 0, 0);
    send(OP_COEF, 0, 0, 0, 48'sh40000000);
    send(OP_SAMPLE, 24'sh7FFFFF, 0, 0, 0);
    send(OP_SAMPLE, 24'sh800000, 0, 0, 0);
    send(OP_COEF, 0, 0, 0, 48'sh7FFFFFFFFFFF);
    send(OP_COEF, 0, 0, 3, 48'sh800000000000);
    send(OP_COEF, 0, 0, 4, 48'shFFFFC0000000);
    send(OP_COEF, 0, 0, 1, 48'sh20000000);
    send(OP_COEF, 0, 0, 2, 48'shE0000000);
    send(OP_SAMPLE, 24'sh7FFFFF, 0, 0, 0);
    send(OP_SAMPLE, 24'sh800000, 0, 0, 0);
    send(OP_STATE, 0, 0, 0, 48'sh7FFFFFFFFFFF);
    send(OP_STATE, 0, 0, 1, 48'sh800000000000);
    send(OP_SAMPLE, 0, 0, 0, 0);
    send(OP_COEF, 0, 0, 5, 48'sh12345);
    send(OP_STATE, 0, 1, 2, 48'sh12345);
    send(OP_NONE, 24'sh123456, 7, 7, 48'sh7FFF);
    send(OP_SAMPLE, 24'sh000001, 7, 7, 48'shFFFFFFFFFFFF);
    set_sections(4'd8);
    send(OP_COEF, 0, 7, 0, 48'sh40000000);
    send(OP_STATE, 0, 7, 0, 48'sh7FFFFFFFFFFF);
    send(OP_SAMPLE, 24'sh7FFFFF, 0, 0, 0);
    set_sections(4'd15);
    send(OP_SAMPLE, 24'sh800000, 0, 0, 0);

    // Random phases over several settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      set_sections(settings[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering transactions.
        fork
          begin
            hold_off = 1'b1;
            repeat (2000) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 150; i++) begin
        random_item();
        if (i == 75) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("parallel_biquad_bank_average_unit_tb passed");
    else
      $display("parallel_biquad_bank_average_unit_tb failed");
    $finish;
  end

endmodule

// ===== parallel_biquad_bank_average_unit.f =====
rtl/pbba_pkg.sv
rtl/pbba_ram.sv
rtl/pbba_div.sv
rtl/parallel_biquad_bank_average_unit.sv
tb/parallel_biquad_bank_average_unit_tb.sv
